// ===== sv/gbs_pkg.sv =====
// shared types and constants of the greedy box suppression block
package gbs_pkg;

   // threshold register: unsigned fraction with 16 fraction bits
   localparam int THR_W = 16;
   localparam int THR_FRAC = 16;
   localparam logic [THR_W-1:0] THR_RESET = 16'd26214;

   // width of the reported position within a set
   localparam int INDEX_W = 10;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_AREA = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

// ===== sv/gbs_if.sv =====
// channel interfaces: box requests, suppression results, threshold writes
interface gbs_req_if #(
   parameter int COORD_WIDTH = 18
) ();
   logic                          valid;
   logic                          ready;
   logic                          first_of_set;
   logic signed [COORD_WIDTH-1:0] box_top;
   logic signed [COORD_WIDTH-1:0] box_left;
   logic signed [COORD_WIDTH-1:0] box_bottom;
   logic signed [COORD_WIDTH-1:0] box_right;

   modport source (
      output valid, first_of_set, box_top, box_left, box_bottom, box_right,
      input  ready
   );
   modport sink (
      input  valid, first_of_set, box_top, box_left, box_bottom, box_right,
      output ready
   );
endinterface

interface gbs_rsp_if ();
   logic                         valid;
   logic                         ready;
   logic                         kept;
   logic [gbs_pkg::INDEX_W-1:0]  box_index;
   logic                         store_overflow;

   modport source (
      output valid, kept, box_index, store_overflow,
      input  ready
   );
   modport sink (
      input  valid, kept, box_index, store_overflow,
      output ready
   );
endinterface

interface gbs_csr_if ();
   logic                        valid;
   logic                        ready;
   logic [gbs_pkg::THR_W-1:0]   overlap_threshold;

   modport source (
      output valid, overlap_threshold,
      input  ready
   );
   modport sink (
      input  valid, overlap_threshold,
      output ready
   );
endinterface

// ===== sv/greedy_box_suppression.sv =====
// greedy non-maximum suppression over a score-sorted stream of boxes
//
// Boxes arrive one beat at a time on req_bus, already sorted by descending
// score; first_of_set empties the kept list and restarts the position count.
// Each box is compared against every box kept so far in the set, read one per
// cycle from a single kept-box memory and pushed through a five-stage overlap
// pipeline (overlap window, intersection multiply, union, split threshold
// multiply, cross-multiplied compare). The time from a box's accept beat to
// its result beat grows with the kept count: it is set by the one read port
// of the kept-box memory, one stored box per cycle, plus the pipeline drain.
// One box is in work at a time; a finished result waits in an output
// register, so the next box is taken while rsp_bus is stalled. A survivor
// found with the list full is reported with store_overflow and is not stored.
// The threshold is to be written on csr_bus only while the block is idle;
// the user is bound by this, the block itself does not enforce it. Memory
// contents need no clearing after reset: only entries below the kept count
// are ever read.
module greedy_box_suppression #(
   parameter int MAX_KEPT    = 64,
   parameter int MAX_BOXES   = 1024,
   parameter int COORD_WIDTH = 18
) (
   input  logic       clock,
   input  logic       reset,
   gbs_req_if.sink    req_bus,
   gbs_rsp_if.source  rsp_bus,
   gbs_csr_if.sink    csr_bus
);

   // derived widths
   localparam int CW     = COORD_WIDTH;
   localparam int DW     = CW + 1;            // edge difference
   localparam int AW     = 2 * DW;            // area and intersection
   localparam int UW     = AW + 2;            // union
   localparam int LOW_W  = UW / 2;            // low half of union, unsigned
   localparam int HIGH_W = UW - LOW_W;        // high half of union, signed
   localparam int THR_W  = gbs_pkg::THR_W;
   localparam int PRW    = THR_W + UW + 1;    // threshold times union
   localparam int WORD_W = 4 * CW + AW;
   localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W  = $clog2(MAX_KEPT + 1);
   localparam int POS_W  = $clog2(MAX_BOXES);

   // kept-box word layout
   localparam int TOP_LSB    = 0;
   localparam int LEFT_LSB   = CW;
   localparam int BOTTOM_LSB = 2 * CW;
   localparam int RIGHT_LSB  = 3 * CW;
   localparam int AREA_LSB   = 4 * CW;

   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_KEPT);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(MAX_BOXES - 1);

   // control state
   gbs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;      // stored boxes in this set
   logic [CNT_W-1:0]   scan_ff, scan_in;        // next entry to read
   logic [POS_W-1:0]   pos_ff, pos_in;          // position of the current box
   logic               supp_ff, supp_in;        // current box hit by some entry
   logic [THR_W-1:0]   thr_ff, thr_in;

   // current box
   logic signed [CW-1:0] box_top_ff, box_left_ff, box_bottom_ff, box_right_ff;
   logic signed [DW-1:0] dw_ff, dw_in, dh_ff, dh_in;
   logic signed [AW-1:0] area_ff, area_in;

   // kept-box memory ports
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;

   // overlap pipeline
   logic                 rd_valid_ff;
   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                 s1_hit_ff, s1_hit_in;
   logic signed [DW-1:0] s1_w_ff, s1_w_in, s1_h_ff, s1_h_in;
   logic signed [AW-1:0] s1_karea_ff;
   logic signed [AW-1:0] s2_inter_ff, s2_inter_in, s2_karea_ff;
   logic signed [AW-1:0] s3_inter_ff;
   logic signed [UW-1:0] s3_uni_ff, s3_uni_in;
   logic signed [AW-1:0] s4_inter_ff;
   logic                 s4_zero_ff, s4_neg_ff;
   logic signed [THR_W+HIGH_W:0]   s4_phi_ff, s4_phi_in;
   logic        [THR_W+LOW_W-1:0]  s4_plo_ff, s4_plo_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_kept_ff, rsp_kept_in;
   logic [gbs_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic req_beat;
   logic rsp_free;
   logic pipe_busy;

   assign req_bus.ready = (state_ff == gbs_pkg::ST_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign pipe_busy     = rd_valid_ff || s1_valid_ff || s2_valid_ff ||
                          s3_valid_ff || s4_valid_ff;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.kept           = rsp_kept_ff;
   assign rsp_bus.box_index      = rsp_index_ff;
   assign rsp_bus.store_overflow = rsp_ovf_ff;

   // kept boxes: top, left, bottom, right and area in one word per entry
   gbs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_KEPT)
   ) u_kept_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one read a cycle while entries remain; the append goes to the count slot
   assign rd_en   = (state_ff == gbs_pkg::ST_SCAN) && (scan_ff != count_ff);
   assign rd_addr = scan_ff[ADDR_W-1:0];
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = {area_ff, box_right_ff, box_bottom_ff, box_left_ff, box_top_ff};

   // stage 1: overlap window of the current box with the entry just read
   logic signed [CW-1:0] k_top, k_left, k_bottom, k_right;
   logic signed [AW-1:0] k_area;
   logic signed [CW-1:0] min_r, max_l, min_b, max_t;

   assign k_top    = rd_data[TOP_LSB +: CW];
   assign k_left   = rd_data[LEFT_LSB +: CW];
   assign k_bottom = rd_data[BOTTOM_LSB +: CW];
   assign k_right  = rd_data[RIGHT_LSB +: CW];
   assign k_area   = rd_data[AREA_LSB +: AW];

   always_comb begin
      min_r = (box_right_ff < k_right) ? box_right_ff : k_right;
      max_l = (box_left_ff > k_left) ? box_left_ff : k_left;
      min_b = (box_bottom_ff < k_bottom) ? box_bottom_ff : k_bottom;
      max_t = (box_top_ff > k_top) ? box_top_ff : k_top;
      // touching edges still count as overlapping, possibly with zero size
      s1_hit_in = !(box_top_ff > k_bottom || box_bottom_ff < k_top ||
                    box_left_ff > k_right || box_right_ff < k_left);
      s1_w_in = DW'(min_r) - DW'(max_l);
      s1_h_in = DW'(min_b) - DW'(max_t);
   end

   // stage 2: intersection
   always_comb begin
      if (s1_hit_ff) begin
         s2_inter_in = s1_w_ff * s1_h_ff;
      end else begin
         s2_inter_in = '0;
      end
   end

   // stage 3: union, signed, may be zero or negative for inverted boxes
   assign s3_uni_in = UW'(area_ff) + UW'(s2_karea_ff) - UW'(s2_inter_ff);

   // stage 4: threshold times union in two partial products
   logic signed [HIGH_W-1:0] uni_hi;
   logic        [LOW_W-1:0]  uni_lo;
   logic signed [THR_W:0]    thr_s;

   assign uni_hi    = s3_uni_ff[UW-1:LOW_W];
   assign uni_lo    = s3_uni_ff[LOW_W-1:0];
   assign thr_s     = $signed({1'b0, thr_ff});
   assign s4_phi_in = thr_s * uni_hi;
   assign s4_plo_in = thr_ff * uni_lo;

   // stage 5: intersection * 2^16 against threshold * union
   logic signed [PRW-1:0] prod, lhs;
   logic                  inter_pos;
   logic                  exceeds;

   always_comb begin
      prod      = (PRW'(s4_phi_ff) <<< LOW_W) + $signed(PRW'(s4_plo_ff));
      lhs       = PRW'(s4_inter_ff) <<< gbs_pkg::THR_FRAC;
      inter_pos = !s4_inter_ff[AW-1] && (s4_inter_ff != '0);
      if (s4_zero_ff) begin
         exceeds = inter_pos;
      end else if (s4_neg_ff) begin
         // negative union flips the sense, as a true division would
         exceeds = lhs < prod;
      end else begin
         exceeds = lhs > prod;
      end
   end

   // sequencing of one box
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pos_in       = pos_ff;
      supp_in      = supp_ff;
      thr_in       = thr_ff;
      dw_in        = dw_ff;
      dh_in        = dh_ff;
      area_in      = area_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_kept_in  = rsp_kept_ff;
      rsp_index_in = rsp_index_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (csr_bus.valid) begin
         thr_in = csr_bus.overlap_threshold;
      end

      if (s4_valid_ff && exceeds) begin
         supp_in = 1'b1;
      end

      if (rd_en) begin
         scan_in = scan_ff + CNT_W'(1);
      end

      unique case (state_ff)
         gbs_pkg::ST_IDLE: begin
            if (req_beat) begin
               supp_in = 1'b0;
               scan_in = '0;
               dw_in   = DW'(req_bus.box_right) - DW'(req_bus.box_left);
               dh_in   = DW'(req_bus.box_bottom) - DW'(req_bus.box_top);
               if (req_bus.first_of_set) begin
                  count_in = '0;
                  pos_in   = '0;
               end
               state_in = gbs_pkg::ST_AREA;
            end
         end
         gbs_pkg::ST_AREA: begin
            area_in  = dw_ff * dh_ff;
            state_in = gbs_pkg::ST_SCAN;
         end
         gbs_pkg::ST_SCAN: begin
            // all entries issued and the last compare retired
            if (scan_ff == count_ff && !pipe_busy) begin
               state_in = gbs_pkg::ST_DONE;
            end
         end
         gbs_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kept_in  = !supp_ff;
               rsp_index_in = gbs_pkg::INDEX_W'(pos_ff);
               rsp_ovf_in   = !supp_ff && (count_ff == COUNT_FULL);
               if (!supp_ff && count_ff != COUNT_FULL) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               // position saturates at the last index
               if (pos_ff != POS_LAST) begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = gbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gbs_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbs_pkg::ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         pos_ff       <= '0;
         supp_ff      <= 1'b0;
         thr_ff       <= gbs_pkg::THR_RESET;
         rd_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         pos_ff       <= pos_in;
         supp_ff      <= supp_in;
         thr_ff       <= thr_in;
         rd_valid_ff  <= rd_en;
         s1_valid_ff  <= rd_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         box_top_ff    <= req_bus.box_top;
         box_left_ff   <= req_bus.box_left;
         box_bottom_ff <= req_bus.box_bottom;
         box_right_ff  <= req_bus.box_right;
      end
      dw_ff        <= dw_in;
      dh_ff        <= dh_in;
      area_ff      <= area_in;
      s1_hit_ff    <= s1_hit_in;
      s1_w_ff      <= s1_w_in;
      s1_h_ff      <= s1_h_in;
      s1_karea_ff  <= k_area;
      s2_inter_ff  <= s2_inter_in;
      s2_karea_ff  <= s1_karea_ff;
      s3_inter_ff  <= s2_inter_ff;
      s3_uni_ff    <= s3_uni_in;
      s4_inter_ff  <= s3_inter_ff;
      s4_zero_ff   <= (s3_uni_ff == '0);
      s4_neg_ff    <= s3_uni_ff[UW-1];
      s4_phi_ff    <= s4_phi_in;
      s4_plo_ff    <= s4_plo_in;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

// ===== sv/gbs_ram.sv =====
// generic single-clock ram, one write port, one registered read port
module gbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gbs_checker.sv =====
// port-level assertions for the greedy box suppression block, with bind
module gbs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_kept,
   input logic [gbs_pkg::INDEX_W-1:0] rsp_box_index,
   input logic                        rsp_store_overflow
);

   // stalled result beat stays valid and holds its index
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_box_index))
      else $error("result beat dropped or changed while stalled");

   // overflow only on a survivor
   a_ovf_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_overflow |-> rsp_kept)
      else $error("store overflow on a suppressed box");

   // one box in work at a time
   a_one_box: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second box taken while one is in work");

   // no result can appear right after a box beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early after a box beat");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_kept           (rsp_bus.kept),
   .rsp_box_index      (rsp_bus.box_index),
   .rsp_store_overflow (rsp_bus.store_overflow)
);
